// ===== rtl/core/scm_pkg.sv =====
// scm_pkg: shared types and constants of the size class mapper
// used by every module under rtl/core; depends on nothing

package scm_pkg;

  // field widths
  localparam int REQ_W    = 32;
  localparam int ALIGN_W  = 33;
  localparam int IDX_W    = 8;
  localparam int FETCH_W  = 10;
  localparam int PAGES_W  = 7;
  localparam int STATUS_W = 2;

  // page size and small-object range
  localparam int PAGE_BITS   = 13;
  localparam int SMALL_LIMIT = 262144;
  localparam int PAGE_MASK   = (1 << PAGE_BITS) - 1;

  // small sizes fit this width (SMALL_LIMIT itself included)
  localparam int SM_W = 19;

  // fetch clamping: below DIV_LO the quotient exceeds FETCH_MAX,
  // above DIV_HI it drops under FETCH_MIN
  localparam int FETCH_MAX = 512;
  localparam int FETCH_MIN = 2;
  localparam int DIV_LO    = SMALL_LIMIT / FETCH_MAX;
  localparam int DIV_HI    = SMALL_LIMIT / FETCH_MIN;

  // one quotient bit per cell; remainder starts at the dividend's upper part
  localparam int DIV_STEPS = FETCH_W;
  localparam int REM_INIT  = SMALL_LIMIT >> DIV_STEPS;

  localparam int PROD_W    = FETCH_W + SM_W;
  localparam int PAGES_MAX = (1 << PAGES_W) - 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_SMALL = 2'd0,
    ST_LARGE = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSEL_DIV = 2'd0,
    FSEL_MAX = 2'd1,
    FSEL_MIN = 2'd2
  } fsel_t;

  typedef struct packed {
    status_t              status;
    logic [ALIGN_W-1:0]   aligned;
    logic [IDX_W-1:0]     idx;
    fsel_t                fsel;
    logic [SM_W-1:0]      rem;
    logic [FETCH_W-1:0]   quot;
  } item_t;

endpackage

// ===== rtl/core/scm_front.sv =====
// scm_front: classifies a request, rounds it up and picks its class index
// registers the result into the divider chain; depends on scm_pkg

module scm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scm_pkg::REQ_W-1:0]   in_request_bytes,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scm_pkg::item_t              out_item
);

  logic                      valid_r;
  scm_pkg::item_t            item_r;
  scm_pkg::item_t            item_nxt;
  logic [scm_pkg::SM_W-1:0]  m;
  logic [scm_pkg::SM_W-1:0]  al;
  logic [scm_pkg::SM_W-1:0]  ix;
  logic [scm_pkg::ALIGN_W-1:0] big;

  function automatic logic [scm_pkg::SM_W-1:0] rnd(
    input logic [scm_pkg::SM_W-1:0] v,
    input int unsigned              sh
  );
    logic [scm_pkg::SM_W-1:0] msk;
    msk = (scm_pkg::SM_W'(1) << sh) - scm_pkg::SM_W'(1);
    return (v + msk) & ~msk;
  endfunction

  // floor((v - base - 1) / 2^sh) + offset
  function automatic logic [scm_pkg::SM_W-1:0] bkt(
    input logic [scm_pkg::SM_W-1:0] v,
    input logic [scm_pkg::SM_W-1:0] base,
    input int unsigned              sh,
    input logic [scm_pkg::SM_W-1:0] offs
  );
    logic [scm_pkg::SM_W-1:0] d;
    d = v - base - scm_pkg::SM_W'(1);
    return (d >> sh) + offs;
  endfunction

  always_comb begin
    m   = in_request_bytes[scm_pkg::SM_W-1:0];
    big = ({1'b0, in_request_bytes} + scm_pkg::ALIGN_W'(scm_pkg::PAGE_MASK))
          & ~scm_pkg::ALIGN_W'(scm_pkg::PAGE_MASK);

    if (m <= scm_pkg::SM_W'(128)) begin
      al = rnd(m, 3);
      ix = bkt(m, scm_pkg::SM_W'(0), 3, scm_pkg::SM_W'(0));
    end else if (m <= scm_pkg::SM_W'(1024)) begin
      al = rnd(m, 4);
      ix = bkt(m, scm_pkg::SM_W'(128), 4, scm_pkg::SM_W'(16));
    end else if (m <= scm_pkg::SM_W'(8192)) begin
      al = rnd(m, 7);
      ix = bkt(m, scm_pkg::SM_W'(1024), 7, scm_pkg::SM_W'(72));
    end else if (m <= scm_pkg::SM_W'(65536)) begin
      al = rnd(m, 10);
      ix = bkt(m, scm_pkg::SM_W'(8192), 10, scm_pkg::SM_W'(128));
    end else begin
      al = rnd(m, 13);
      ix = bkt(m, scm_pkg::SM_W'(65536), 13, scm_pkg::SM_W'(184));
    end

    item_nxt.rem  = scm_pkg::SM_W'(scm_pkg::REM_INIT);
    item_nxt.quot = '0;

    if (in_request_bytes == '0) begin
      item_nxt.status  = scm_pkg::ST_ZERO;
      item_nxt.aligned = '0;
      item_nxt.idx     = '0;
      item_nxt.fsel    = scm_pkg::FSEL_MAX;
    end else if (in_request_bytes > scm_pkg::REQ_W'(scm_pkg::SMALL_LIMIT)) begin
      item_nxt.status  = scm_pkg::ST_LARGE;
      item_nxt.aligned = big;
      item_nxt.idx     = '0;
      item_nxt.fsel    = scm_pkg::FSEL_MIN;
    end else begin
      item_nxt.status  = scm_pkg::ST_SMALL;
      item_nxt.aligned = scm_pkg::ALIGN_W'(al);
      item_nxt.idx     = ix[scm_pkg::IDX_W-1:0];
      if (al < scm_pkg::SM_W'(scm_pkg::DIV_LO)) begin
        item_nxt.fsel = scm_pkg::FSEL_MAX;
      end else if (al > scm_pkg::SM_W'(scm_pkg::DIV_HI)) begin
        item_nxt.fsel = scm_pkg::FSEL_MIN;
      end else begin
        item_nxt.fsel = scm_pkg::FSEL_DIV;
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/scm_div_cell.sv =====
// scm_div_cell: one restoring-division step, yields one bit of the fetch count
// a chain of these divides the small limit by the aligned size; depends on scm_pkg

module scm_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  scm_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output scm_pkg::item_t out_item
);

  logic                      valid_r;
  scm_pkg::item_t            item_r;
  scm_pkg::item_t            item_nxt;
  logic [scm_pkg::SM_W-1:0]  dvs;
  logic [scm_pkg::SM_W-1:0]  shl;
  logic                      ge;

  // dividend low bits are all zero, so each step just doubles the remainder
  always_comb begin
    dvs  = in_item.aligned[scm_pkg::SM_W-1:0];
    shl  = {in_item.rem[scm_pkg::SM_W-2:0], 1'b0};
    ge   = (shl >= dvs);
    item_nxt      = in_item;
    item_nxt.rem  = ge ? (shl - dvs) : shl;
    item_nxt.quot = {in_item.quot[scm_pkg::FETCH_W-2:0], ge};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/scm_back.sv =====
// scm_back: clamps the fetch count, computes pages per batch, holds the result
// output register of the mapper; depends on scm_pkg

module scm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scm_pkg::item_t                 in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scm_pkg::ALIGN_W-1:0]    out_aligned_bytes,
  output logic [scm_pkg::IDX_W-1:0]      out_class_index,
  output logic [scm_pkg::FETCH_W-1:0]    out_fetch_count,
  output logic [scm_pkg::PAGES_W-1:0]    out_page_count,
  output logic [scm_pkg::STATUS_W-1:0]   out_status
);

  logic                           valid_r;
  logic [scm_pkg::ALIGN_W-1:0]    aligned_r;
  logic [scm_pkg::IDX_W-1:0]      idx_r;
  logic [scm_pkg::FETCH_W-1:0]    fetch_r;
  logic [scm_pkg::PAGES_W-1:0]    pages_r;
  scm_pkg::status_t               status_r;

  logic [scm_pkg::FETCH_W-1:0]    fetch_nxt;
  logic [scm_pkg::PAGES_W-1:0]    pages_nxt;
  logic [scm_pkg::FETCH_W-1:0]    fetch;
  logic [scm_pkg::PROD_W-1:0]     prod;
  logic [scm_pkg::PROD_W-1:0]     pg;
  logic                           is_small;

  always_comb begin
    is_small = (in_item.status == scm_pkg::ST_SMALL);
    case (in_item.fsel)
      scm_pkg::FSEL_DIV: fetch = in_item.quot;
      scm_pkg::FSEL_MAX: fetch = scm_pkg::FETCH_W'(scm_pkg::FETCH_MAX);
      scm_pkg::FSEL_MIN: fetch = scm_pkg::FETCH_W'(scm_pkg::FETCH_MIN);
      default:           fetch = scm_pkg::FETCH_W'(scm_pkg::FETCH_MIN);
    endcase
    prod = scm_pkg::PROD_W'(fetch)
         * scm_pkg::PROD_W'(in_item.aligned[scm_pkg::SM_W-1:0]);
    pg   = prod >> scm_pkg::PAGE_BITS;
    if (!is_small) begin
      fetch_nxt = '0;
      pages_nxt = '0;
    end else begin
      fetch_nxt = fetch;
      if (pg == '0) begin
        pages_nxt = scm_pkg::PAGES_W'(1);
      end else if (pg > scm_pkg::PROD_W'(scm_pkg::PAGES_MAX)) begin
        pages_nxt = scm_pkg::PAGES_W'(scm_pkg::PAGES_MAX);
      end else begin
        pages_nxt = pg[scm_pkg::PAGES_W-1:0];
      end
    end
  end

  assign in_ready          = !valid_r || out_ready;
  assign out_valid         = valid_r;
  assign out_aligned_bytes = aligned_r;
  assign out_class_index   = idx_r;
  assign out_fetch_count   = fetch_r;
  assign out_page_count    = pages_r;
  assign out_status        = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      aligned_r <= in_item.aligned;
      idx_r     <= in_item.idx;
      fetch_r   <= fetch_nxt;
      pages_r   <= pages_nxt;
      status_r  <= in_item.status;
    end
  end

endmodule

// ===== rtl/core/size_class_mapper_top.sv =====
// size_class_mapper_top: top level of the allocation size class mapper
// instantiates scm_front, a chain of scm_div_cell and scm_back; depends on scm_pkg
//
// usage
//   input channel: in_valid / in_ready with in_request_bytes, one transaction
//   per request size; result channel: out_valid / out_ready with the aligned
//   size, class index, fetch count, page count and status of that request
//   every request gives exactly one result, in request order
// pipeline and throughput
//   out_valid rises once a request has passed twelve register stages
//   (one classify stage, ten division cells with one quotient bit of the fetch
//   count each, and the page/output stage), the first loaded at the accepting
//   edge; one transaction per cycle sustained while out_ready stays high
// stalls
//   each stage holds its own valid bit and ready is passed back stage by
//   stage, so a stalled receiver only fills the pipe; in_ready stays high
//   until every stage holds an item, and bubbles are squeezed out meanwhile
// reset
//   synchronous active-low rst_n empties the pipe; no other state is kept

module size_class_mapper_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [scm_pkg::REQ_W-1:0]      in_request_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [scm_pkg::ALIGN_W-1:0]    out_aligned_bytes,
  output logic [scm_pkg::IDX_W-1:0]      out_class_index,
  output logic [scm_pkg::FETCH_W-1:0]    out_fetch_count,
  output logic [scm_pkg::PAGES_W-1:0]    out_page_count,
  output logic [scm_pkg::STATUS_W-1:0]   out_status
);

  // chain_* [k] is the link entering division cell k; the last one feeds the back end
  scm_pkg::item_t chain_item  [scm_pkg::DIV_STEPS+1];
  logic           chain_valid [scm_pkg::DIV_STEPS+1];
  logic           chain_ready [scm_pkg::DIV_STEPS+1];

  // classify, round up and index the request
  scm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_request_bytes (in_request_bytes),
    .out_valid        (chain_valid[0]),
    .out_ready        (chain_ready[0]),
    .out_item         (chain_item[0])
  );

  // fetch count = small limit / aligned size, one quotient bit per cell
  for (genvar k = 0; k < scm_pkg::DIV_STEPS; k++) begin : g_cell
    scm_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  // clamp fetch, compute pages per batch, output register
  scm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (chain_valid[scm_pkg::DIV_STEPS]),
    .in_ready          (chain_ready[scm_pkg::DIV_STEPS]),
    .in_item           (chain_item[scm_pkg::DIV_STEPS]),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_aligned_bytes (out_aligned_bytes),
    .out_class_index   (out_class_index),
    .out_fetch_count   (out_fetch_count),
    .out_page_count    (out_page_count),
    .out_status        (out_status)
  );

  // non-small results carry no class, fetch or page figures
  a_nonsmall_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != scm_pkg::ST_SMALL) |->
      (out_class_index == '0 && out_fetch_count == '0 && out_page_count == '0))
    else $error("non-small result carries class data");

  // small results stay within the clamped fetch range and ask for a page at least
  a_small_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == scm_pkg::ST_SMALL) |->
      (out_fetch_count >= scm_pkg::FETCH_W'(scm_pkg::FETCH_MIN) &&
       out_fetch_count <= scm_pkg::FETCH_W'(scm_pkg::FETCH_MAX) &&
       out_page_count != '0 && out_aligned_bytes[2:0] == 3'd0 &&
       out_aligned_bytes <= scm_pkg::ALIGN_W'(scm_pkg::SMALL_LIMIT)))
    else $error("small result out of range");

  // large results are whole pages
  a_large_paged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == scm_pkg::ST_LARGE) |->
      (out_aligned_bytes[scm_pkg::PAGE_BITS-1:0] == '0 &&
       out_aligned_bytes > scm_pkg::ALIGN_W'(scm_pkg::SMALL_LIMIT)))
    else $error("large result not page aligned");

endmodule
